/* rtl/msched_pkg.sv */
// ----------------------------------------------------------------------------
// msched_pkg
// Shared widths, codes and types for the multi-policy task scheduler.
// ----------------------------------------------------------------------------
package msched_pkg;

  localparam int MAX_TASKS = 32;
  localparam int TIME_W    = 24;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int QNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [QNT_W-1:0] QUANTUM_RESET = QNT_W'(500);

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY  = 2'd0,
    REG_QUANTUM = 2'd1,
    REG_COUNT   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Shared compare unit result
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

/* rtl/msched_cmp.sv */
// ----------------------------------------------------------------------------
// msched_cmp
// Shared time-width magnitude comparator used by arrival and selection scans.
// ----------------------------------------------------------------------------
module msched_cmp (
  input  logic [msched_pkg::TIME_W-1:0] a,
  input  logic [msched_pkg::TIME_W-1:0] b,
  output msched_pkg::cmp_res_t          res
);

  assign res.eq = (a == b);
  assign res.lt = (a < b);

endmodule

/* rtl/multi_policy_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler_core
// FIFO / round robin / SJF / preemptive SJF scheduler, one iteration per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, task_index, ready_time and
//   exec_time. A load item (op 0) writes one task slot and makes
//   no result. A tick item (op 1) runs one scheduler iteration and makes
//   exactly one result item on the output channel (out_valid/out_ready).
//   Config channel (cfg_valid/cfg_ready) writes policy, time_quantum and
//   task_count; it is always ready and should only be used while idle.
// Operation:
//   A tick walks the task slots once for arrivals and, if the policy needs a
//   search, once more for the best key, via one memory read port and one
//   shared comparator. A retirement that completes the set, and any later tick,
//   skips the walks and goes straight to the result. One item at a time.
// Reset:
//   Clears control state, launched/done bits, queue pointers, time and the
//   registers to their defaults. Slot and queue memories are not cleared.
// Stall:
//   The result sits in the output register; the block may take further
//   loads meanwhile, but a tick waits before handing over its result.
// ----------------------------------------------------------------------------
module multi_policy_task_scheduler_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [4:0]                           task_index,
  input  logic [msched_pkg::TIME_W-1:0]        ready_time,
  input  logic [msched_pkg::TIME_W-1:0]        exec_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 running_valid,
  output logic [4:0]                           running_task,
  output logic                                 switched,
  output logic                                 finished_valid,
  output logic [4:0]                           finished_task,
  output logic                                 all_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msched_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msched_pkg::QNT_W-1:0]         cfg_data
);

  localparam int TW = msched_pkg::TIME_W;
  localparam int IW = msched_pkg::IDX_W;
  localparam int CW = msched_pkg::CNT_W;
  localparam int QW = msched_pkg::QNT_W;
  localparam int MT = msched_pkg::MAX_TASKS;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_RET_RD  = 12'b0000_0000_0010,
    S_RET_CHK = 12'b0000_0000_0100,
    S_LAUNCH  = 12'b0000_0000_1000,
    S_SEL     = 12'b0000_0001_0000,
    S_POP     = 12'b0000_0010_0000,
    S_POPT    = 12'b0000_0100_0000,
    S_SCAN    = 12'b0000_1000_0000,
    S_SW      = 12'b0001_0000_0000,
    S_RUN_RD  = 12'b0010_0000_0000,
    S_RUN     = 12'b0100_0000_0000,
    S_OUT     = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // config registers
  msched_pkg::policy_t policy;
  logic [QW-1:0] time_quantum;
  logic [CW-1:0] task_count;

  // slot and queue memories
  logic [TW-1:0] ready_mem [MT];
  logic [TW-1:0] rem_mem   [MT];
  logic [IW-1:0] rr_mem    [MT];
  logic [TW-1:0] ready_q;
  logic [TW-1:0] rem_q;
  logic [IW-1:0] head_q;
  logic [IW-1:0] rd_addr;

  logic [MT-1:0] launched;
  logic [MT-1:0] done;
  logic [IW-1:0] rr_head;
  logic [IW-1:0] rr_tail;
  logic [CW-1:0] rr_count;
  logic [TW-1:0] current_time;
  logic [QW-1:0] slice_counter;
  logic [IW-1:0] running_index;
  logic          running_flag;
  logic [CW-1:0] finished_count;

  // per-tick working registers
  logic [CW-1:0] scan_idx;
  logic          pipe_vld;
  logic [IW-1:0] pipe_idx;
  logic          has_next;
  logic [IW-1:0] next_idx;
  logic [TW-1:0] best_key;
  logic [TW-1:0] runner_rem;
  logic          res_sw;
  logic          res_fin_v;
  logic [IW-1:0] res_fin_t;
  logic          res_run_v;
  logic [IW-1:0] res_run_t;
  logic          res_done;

  logic [CW-1:0] n_act;
  logic [QW-1:0] q_eff;
  logic          issue;
  logic [TW-1:0] cmp_a;
  logic [TW-1:0] cmp_b;
  msched_pkg::cmp_res_t cmp_res;
  logic          rr_push_ok;
  logic [CW-1:0] fc_inc;
  logic [QW:0]   slice_inc;

  assign n_act = (task_count > CW'(MT)) ? CW'(MT) : task_count;
  assign q_eff = (time_quantum == '0) ? QW'(1) : time_quantum;
  assign issue = (scan_idx < n_act);
  assign rr_push_ok = (rr_count < CW'(MT));
  assign fc_inc = finished_count + CW'(1);
  assign slice_inc = {1'b0, slice_counter} + (QW+1)'(1);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // one shared comparator: arrival match during launch, key order during scan
  always_comb begin
    if (state == S_LAUNCH) begin
      cmp_a = ready_q;
      cmp_b = current_time;
    end else begin
      cmp_a = (policy == msched_pkg::POL_FIFO) ? ready_q : rem_q;
      cmp_b = best_key;
    end
  end

  msched_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    if (state == S_LAUNCH || state == S_SCAN) begin
      rd_addr = scan_idx[IW-1:0];
    end else begin
      rd_addr = running_index;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    ready_q <= ready_mem[rd_addr];
    rem_q   <= rem_mem[rd_addr];
    head_q  <= rr_mem[rr_head];
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= msched_pkg::POL_FIFO;
      time_quantum <= msched_pkg::QUANTUM_RESET;
      task_count   <= CW'(1);
    end else if (cfg_valid) begin
      unique case (msched_pkg::reg_idx_t'(cfg_index))
        msched_pkg::REG_POLICY:  policy <= msched_pkg::policy_t'(cfg_data[1:0]);
        msched_pkg::REG_QUANTUM: time_quantum <= cfg_data;
        msched_pkg::REG_COUNT:   task_count <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      launched       <= '0;
      done           <= '0;
      rr_head        <= '0;
      rr_tail        <= '0;
      rr_count       <= '0;
      current_time   <= '0;
      slice_counter  <= '0;
      running_index  <= '0;
      running_flag   <= 1'b0;
      finished_count <= '0;
      out_valid      <= 1'b0;
      scan_idx       <= '0;
      pipe_vld       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (msched_pkg::op_t'(op) == msched_pkg::OP_LOAD) begin
              if ({1'b0, task_index} < CW'(MT)) begin
                ready_mem[task_index[IW-1:0]] <= ready_time;
                rem_mem[task_index[IW-1:0]]   <= (exec_time == '0) ? TW'(1) : exec_time;
                launched[task_index[IW-1:0]]  <= 1'b0;
                done[task_index[IW-1:0]]      <= 1'b0;
              end
            end else begin
              res_sw    <= 1'b0;
              res_fin_v <= 1'b0;
              res_fin_t <= '0;
              res_run_v <= 1'b0;
              res_run_t <= '0;
              res_done  <= 1'b0;
              if (finished_count >= n_act) begin
                res_done <= 1'b1;
                state    <= S_OUT;
              end else begin
                state <= S_RET_RD;
              end
            end
          end
        end
        S_RET_RD: state <= S_RET_CHK;
        S_RET_CHK: begin
          runner_rem <= rem_q;
          scan_idx   <= '0;
          pipe_vld   <= 1'b0;
          state      <= S_LAUNCH;
          if (running_flag && rem_q == '0) begin
            done[running_index] <= 1'b1;
            res_fin_v           <= 1'b1;
            res_fin_t           <= running_index;
            running_flag        <= 1'b0;
            finished_count      <= fc_inc;
            if (fc_inc >= n_act) begin
              res_done <= 1'b1;
              state    <= S_OUT;
            end
          end
        end
        S_LAUNCH: begin
          pipe_vld <= issue;
          pipe_idx <= scan_idx[IW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (pipe_vld && !launched[pipe_idx] && cmp_res.eq) begin
            launched[pipe_idx] <= 1'b1;
            if (rr_push_ok) begin
              rr_mem[rr_tail] <= pipe_idx;
              rr_tail  <= (rr_tail == IW'(MT - 1)) ? '0 : rr_tail + IW'(1);
              rr_count <= rr_count + CW'(1);
            end
          end
          if (!issue && !pipe_vld) begin
            state <= S_SEL;
          end
        end
        S_SEL: begin
          has_next <= 1'b0;
          next_idx <= '0;
          scan_idx <= '0;
          pipe_vld <= 1'b0;
          priority if (running_flag && (policy == msched_pkg::POL_FIFO ||
                                        policy == msched_pkg::POL_SJF)) begin
            has_next <= 1'b1;
            next_idx <= running_index;
            state    <= S_SW;
          end else if (policy == msched_pkg::POL_RR) begin
            if (!running_flag) begin
              state <= (rr_count != '0) ? S_POP : S_SW;
            end else if (slice_counter == '0) begin
              // slice expired: requeue the runner, then pop the head
              if (runner_rem != '0 && rr_push_ok) begin
                rr_mem[rr_tail] <= running_index;
                rr_tail  <= (rr_tail == IW'(MT - 1)) ? '0 : rr_tail + IW'(1);
                rr_count <= rr_count + CW'(1);
                state    <= S_POP;
              end else begin
                state <= (rr_count != '0) ? S_POP : S_SW;
              end
            end else begin
              has_next <= 1'b1;
              next_idx <= running_index;
              state    <= S_SW;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_POP: state <= S_POPT;
        S_POPT: begin
          has_next <= 1'b1;
          next_idx <= head_q;
          rr_head  <= (rr_head == IW'(MT - 1)) ? '0 : rr_head + IW'(1);
          rr_count <= rr_count - CW'(1);
          state    <= S_SW;
        end
        S_SCAN: begin
          pipe_vld <= issue;
          pipe_idx <= scan_idx[IW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (pipe_vld && launched[pipe_idx] && !done[pipe_idx] && rem_q != '0) begin
            if (!has_next || cmp_res.lt) begin
              has_next <= 1'b1;
              next_idx <= pipe_idx;
              best_key <= cmp_a;
            end
          end
          if (!issue && !pipe_vld) begin
            state <= S_SW;
          end
        end
        S_SW: begin
          if (has_next && (!running_flag || next_idx != running_index)) begin
            running_index <= next_idx;
            running_flag  <= 1'b1;
            slice_counter <= '0;
            res_sw        <= 1'b1;
          end
          state <= S_RUN_RD;
        end
        S_RUN_RD: state <= S_RUN;
        S_RUN: begin
          if (running_flag) begin
            if (rem_q != '0) begin
              rem_mem[running_index] <= rem_q - TW'(1);
            end
            res_run_v <= 1'b1;
            res_run_t <= running_index;
          end
          current_time  <= current_time + TW'(1);
          slice_counter <= (slice_inc >= {1'b0, q_eff}) ? '0 : slice_inc[QW-1:0];
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            running_valid  <= res_run_v;
            running_task   <= res_run_t;
            switched       <= res_sw;
            finished_valid <= res_fin_v;
            finished_task  <= res_fin_t;
            all_done       <= res_done;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/msched_checker.sv */
// ----------------------------------------------------------------------------
// msched_checker
// Port-level checks on the scheduler result channel, bound to the top level.
// ----------------------------------------------------------------------------
module msched_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       running_valid,
  input logic [4:0] running_task,
  input logic       switched,
  input logic       finished_valid,
  input logic [4:0] finished_task,
  input logic       all_done
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_task) && $stable(switched))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_done |-> !running_valid && !switched)
    else $error("task ran after completion");

  a_sw_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> running_valid)
    else $error("switch without a running task");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running_valid |-> running_task == 5'd0)
    else $error("idle tick reports a task");

  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished_valid |-> finished_task == 5'd0)
    else $error("retired index without retirement");

endmodule

bind multi_policy_task_scheduler_core msched_checker u_msched_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .running_valid  (running_valid),
  .running_task   (running_task),
  .switched       (switched),
  .finished_valid (finished_valid),
  .finished_task  (finished_task),
  .all_done       (all_done)
);
